@@ hdl/pru_pkg.sv @@
`timescale 1ns / 1ps
// Package for the PNG row unfilter: filter codes, configuration register
// indexes, size defaults and the Paeth predictor. No dependencies.
package pru_pkg;

  localparam int unsigned MaxRowBytesDef   = 4096;
  localparam int unsigned MaxPixelBytesDef = 8;

  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 13;
  localparam int unsigned BppW     = 4;
  localparam int unsigned RowBytesW = 13;

  typedef enum logic [2:0] {
    FILT_NONE  = 3'd0,
    FILT_SUB   = 3'd1,
    FILT_UP    = 3'd2,
    FILT_AVG   = 3'd3,
    FILT_PAETH = 3'd4
  } filter_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_BYTES_PER_PIXEL = 1'd0,
    CFG_ROW_BYTES       = 1'd1
  } cfg_index_e;

  // Paeth predictor over left (a), above (b) and upper-left (c).
  function automatic logic [7:0] paeth_pred(input logic [7:0] a, input logic [7:0] b,
                                            input logic [7:0] c);
    logic signed [10:0] da;
    logic signed [10:0] db;
    logic signed [10:0] dc;
    logic [9:0] pa;
    logic [9:0] pb;
    logic [9:0] pc;
    da = $signed({3'b000, b}) - $signed({3'b000, c});
    db = $signed({3'b000, a}) - $signed({3'b000, c});
    dc = da + db;
    pa = da[10] ? 10'(-da) : da[9:0];
    pb = db[10] ? 10'(-db) : db[9:0];
    pc = dc[10] ? 10'(-dc) : dc[9:0];
    if ((pa <= pb) && (pa <= pc)) begin
      paeth_pred = a;
    end else if (pb <= pc) begin
      paeth_pred = b;
    end else begin
      paeth_pred = c;
    end
  endfunction

endpackage

@@ hdl/png_row_unfilter.sv @@
`timescale 1ns / 1ps
// PNG row unfilter top level: request tracking, line store and predictor.
// Depends on pru_pkg.
//
// The block takes one inflated byte per cycle and returns one reconstructed
// byte for every filtered data byte; filter code bytes give no result. A data
// byte passes from the input register, where the line store is read, to the
// output register, and a new byte is accepted in every cycle while the output
// side keeps taking results. The throughput of one byte per cycle is set by
// the line store, which has one read port and one write port and is read once
// per byte and written once per data byte. The line store has no reset and
// needs no clearing pass: the first row of each image reads the row above as
// zero, and later rows read only columns that the previous row wrote.
module png_row_unfilter
  import pru_pkg::*;
#(
  parameter int unsigned MaxRowBytes   = MaxRowBytesDef,
  parameter int unsigned MaxPixelBytes = MaxPixelBytesDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [7:0]          data_byte_i,
  input  logic                image_start_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [7:0]          pixel_byte_o,
  output logic                row_last_o,
  output logic                bad_filter_o
);

  localparam int unsigned AddrW = (MaxRowBytes > 1) ? $clog2(MaxRowBytes) : 1;
  localparam int unsigned LenW  = (AddrW + 1 > RowBytesW) ? AddrW + 1 : RowBytesW;
  localparam int unsigned HistW = (MaxPixelBytes > 1) ? $clog2(MaxPixelBytes) : 1;

  logic [BppW-1:0]      bpp_q;
  logic [RowBytesW-1:0] row_bytes_q;

  logic             awaiting_q;
  logic             first_row_q;
  logic [AddrW-1:0] col_q;
  filter_e          filter_q;
  logic             bad_q;

  logic             s1_valid_q;
  logic             s1_data_q;
  logic [7:0]       s1_x_q;
  logic [AddrW-1:0] s1_col_q;
  logic             s1_first_q;
  filter_e          s1_filter_q;
  logic             s1_bad_q;
  logic             s1_last_q;

  logic [7:0] line_store [MaxRowBytes];
  logic [7:0] rd_q;
  logic [7:0] left_q  [MaxPixelBytes];
  logic [7:0] above_q [MaxPixelBytes];

  logic       out_valid_q;
  logic [7:0] pixel_q;
  logic       row_last_q;
  logic       bad_out_q;

  logic             in_fire;
  logic             out_free;
  logic             s1_adv;
  logic             load_out;
  logic             code_bad;
  filter_e          code_filter;
  logic [LenW-1:0]  len_eff;
  logic [LenW-1:0]  col_next;
  logic             col_last;
  logic [BppW-1:0]  idx_full;
  logic [HistW-1:0] hist_idx;
  logic [7:0]       a;
  logic [7:0]       b;
  logic [7:0]       c;
  logic [8:0]       ab_sum;
  logic [7:0]       pred;
  logic [7:0]       r;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bpp_q       <= BppW'(1);
      row_bytes_q <= RowBytesW'(1);
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_BYTES_PER_PIXEL: bpp_q       <= cfg_data_i[BppW-1:0];
        CFG_ROW_BYTES:       row_bytes_q <= cfg_data_i[RowBytesW-1:0];
        default: ;
      endcase
    end
  end

  assign out_free   = !out_valid_q || out_ready_i;
  assign s1_adv     = s1_valid_q && (!s1_data_q || out_free);
  assign in_ready_o = !s1_valid_q || s1_adv;
  assign in_fire    = in_valid_i && in_ready_o;
  assign load_out   = s1_adv && s1_data_q;

  // Request tracking at acceptance: row structure and line store address.
  always_comb begin
    code_bad    = data_byte_i > 8'(FILT_PAETH);
    code_filter = code_bad ? FILT_NONE : filter_e'(data_byte_i[2:0]);
    len_eff     = LenW'(row_bytes_q);
    if (len_eff == '0) begin
      len_eff = LenW'(1);
    end else if (len_eff > LenW'(MaxRowBytes)) begin
      len_eff = LenW'(MaxRowBytes);
    end
    col_next = LenW'(col_q) + LenW'(1);
    col_last = col_next >= len_eff;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      awaiting_q  <= 1'b1;
      first_row_q <= 1'b1;
      col_q       <= '0;
      filter_q    <= FILT_NONE;
      bad_q       <= 1'b0;
    end else if (in_fire) begin
      if (image_start_i || awaiting_q) begin
        if (image_start_i) begin
          first_row_q <= 1'b1;
        end
        filter_q   <= code_filter;
        bad_q      <= code_bad;
        col_q      <= '0;
        awaiting_q <= 1'b0;
      end else if (col_last) begin
        col_q       <= '0;
        awaiting_q  <= 1'b1;
        first_row_q <= 1'b0;
      end else begin
        col_q <= col_next[AddrW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_fire) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_data_q   <= !(image_start_i || awaiting_q);
      s1_x_q      <= data_byte_i;
      s1_col_q    <= col_q;
      s1_first_q  <= first_row_q;
      s1_filter_q <= filter_q;
      s1_bad_q    <= bad_q;
      s1_last_q   <= col_last;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      rd_q <= line_store[col_q];
    end
    if (load_out) begin
      line_store[s1_col_q] <= r;
    end
  end

  // Reconstruction of the byte held in the input register.
  always_comb begin
    idx_full = bpp_q - BppW'(1);
    if (bpp_q == '0) begin
      idx_full = '0;
    end else if (bpp_q > BppW'(MaxPixelBytes)) begin
      idx_full = BppW'(MaxPixelBytes - 1);
    end
    hist_idx = HistW'(idx_full);
    a        = left_q[hist_idx];
    c        = above_q[hist_idx];
    b        = s1_first_q ? 8'd0 : rd_q;
    ab_sum   = {1'b0, a} + {1'b0, b};
    case (s1_filter_q)
      FILT_SUB:   pred = a;
      FILT_UP:    pred = b;
      FILT_AVG:   pred = ab_sum[8:1];
      FILT_PAETH: pred = paeth_pred(a, b, c);
      default:    pred = 8'd0;
    endcase
    r = s1_x_q + pred;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MaxPixelBytes; i++) begin
        left_q[i]  <= 8'd0;
        above_q[i] <= 8'd0;
      end
    end else if (s1_adv) begin
      if (s1_data_q) begin
        for (int i = MaxPixelBytes - 1; i > 0; i--) begin
          left_q[i]  <= left_q[i-1];
          above_q[i] <= above_q[i-1];
        end
        left_q[0]  <= r;
        above_q[0] <= b;
      end else begin
        for (int i = 0; i < MaxPixelBytes; i++) begin
          left_q[i]  <= 8'd0;
          above_q[i] <= 8'd0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      pixel_q    <= r;
      row_last_q <= s1_last_q;
      bad_out_q  <= s1_bad_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign pixel_byte_o = pixel_q;
  assign row_last_o   = row_last_q;
  assign bad_filter_o = bad_out_q;

endmodule
